### hdl/argb_triple_box_blur_defines.svh
`ifndef ARGB_TRIPLE_BOX_BLUR_DEFINES_SVH
`define ARGB_TRIPLE_BOX_BLUR_DEFINES_SVH

// same-cycle implication
`define ABTB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("abtb check failed");

// next-cycle implication
`define ABTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("abtb check failed");

`endif

### hdl/abtb_pkg.sv
package abtb_pkg;

   localparam int DIM_W    = 9;
   localparam int RAD_W    = 6;
   localparam int DIV_W    = RAD_W + 1;
   localparam int CH_W     = 8;
   localparam int SUM_W    = DIV_W + CH_W;
   localparam int NUM_CH   = 4;
   localparam int PIX_W    = NUM_CH * CH_W;
   localparam int TAP_W    = DIM_W + 2;
   localparam int CNT_W    = $clog2(CH_W);

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int MAX_RADIUS     = 63;
   localparam int BLUR_ROUNDS    = 3;
   localparam int ROUND_W        = $clog2(BLUR_ROUNDS + 1);

   localparam int RST_WIDTH  = 256;
   localparam int RST_HEIGHT = 256;
   localparam int RST_RADIUS = 2;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_BLUR  = 2'd1,
      REQ_READ  = 2'd2
   } req_type_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_RADIUS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_READ,
      T_BLUR
   } top_state_type;

   typedef enum logic [3:0] {
      E_IDLE,
      E_LINE_INIT,
      E_PRIME_RD,
      E_PRIME_ACC,
      E_DIV_START,
      E_DIV_WAIT,
      E_WRITE,
      E_ADD_ACC,
      E_SUB_ACC
   } eng_state_type;

   typedef struct packed {
      logic frame_we;
      logic temp_we;
      logic rd_en;
      logic rd_temp;
   } mem_ctl_type;

   function automatic logic [CH_W-1:0] pix_chan(input logic [PIX_W-1:0] p, input int c);
      return p[PIX_W-1-CH_W*c -: CH_W];
   endfunction

   function automatic logic [DIM_W-1:0] clamp_tap(input logic signed [TAP_W-1:0] t,
                                                  input logic [DIM_W-1:0] n);
      logic signed [TAP_W-1:0] ns;
      ns = $signed({2'b00, n});
      if (t < 0) begin
         return '0;
      end else if (t >= ns) begin
         return n - 1'b1;
      end
      return t[DIM_W-1:0];
   endfunction

endpackage

### hdl/abtb_ram.sv
module abtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/abtb_divider.sv
module abtb_divider import abtb_pkg::*; (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [NUM_CH-1:0][SUM_W-1:0]     dividend,
   input  logic [DIV_W-1:0]                 divisor,
   output logic                             done,
   output logic [NUM_CH-1:0][CH_W-1:0]      quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [DIV_W-1:0]              dvs_ff, dvs_in;
   logic [NUM_CH-1:0][SUM_W-1:0]  rem_ff, rem_in;
   logic [NUM_CH-1:0][CH_W-1:0]   quo_ff, quo_in;
   logic [SUM_W-1:0]              shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = SUM_W'(dvs_ff) << cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(CH_W - 1);
         dvs_in  = divisor;
         rem_in  = dividend;
         quo_in  = '0;
      end else if (busy_ff) begin
         for (int c = 0; c < NUM_CH; c++) begin
            if (rem_ff[c] >= shifted) begin
               rem_in[c] = rem_ff[c] - shifted;
               quo_in[c] = {quo_ff[c][CH_W-2:0], 1'b1};
            end else begin
               quo_in[c] = {quo_ff[c][CH_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/abtb_engine.sv
module abtb_engine import abtb_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIM_W-1:0]  img_width,
   input  logic [DIM_W-1:0]  img_height,
   input  logic [RAD_W-1:0]  blur_radius,
   input  logic [PIX_W-1:0]  frame_rd_data,
   input  logic [PIX_W-1:0]  temp_rd_data,
   output mem_ctl_type       mem_ctl,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [ADDR_W-1:0] rd_addr,
   output logic [PIX_W-1:0]  wr_data,
   output logic              done
);

   localparam int WLIM = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
   localparam int HLIM = (MAX_HEIGHT < 511) ? MAX_HEIGHT : 511;
   localparam int RLIM = (MAX_RADIUS < 63) ? MAX_RADIUS : 63;

   eng_state_type                state_ff, state_in;
   logic [ROUND_W-1:0]           round_ff, round_in;
   logic                         vert_ff, vert_in;
   logic [DIM_W-1:0]             line_ff, line_in;
   logic [DIM_W-1:0]             idx_ff, idx_in;
   logic signed [TAP_W-1:0]      tap_ff, tap_in;
   logic [NUM_CH-1:0][SUM_W-1:0] sums_ff, sums_in;
   logic [DIM_W-1:0]             w_ff, w_in, h_ff, h_in;
   logic [RAD_W-1:0]             r_ff, r_in;
   logic                         done_ff, done_in;

   logic [DIM_W-1:0]             n_len, n_lines, rd_pos, wsat, hsat, row, col, wrow, wcol;
   logic [RAD_W-1:0]             rsat;
   logic signed [TAP_W-1:0]      r_tap, idx_tap;
   logic [PIX_W-1:0]             src_data;
   logic                         div_start, div_done;
   logic [NUM_CH-1:0][CH_W-1:0]  quo;

   abtb_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums_ff),
      .divisor  ({r_ff, 1'b1}),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      wsat = (img_width == '0) ? DIM_W'(1) :
             ((int'(img_width) > WLIM) ? DIM_W'(WLIM) : img_width);
      hsat = (img_height == '0) ? DIM_W'(1) :
             ((int'(img_height) > HLIM) ? DIM_W'(HLIM) : img_height);
      rsat = (int'(blur_radius) > RLIM) ? RAD_W'(RLIM) : blur_radius;

      n_len    = vert_ff ? h_ff : w_ff;
      n_lines  = vert_ff ? w_ff : h_ff;
      r_tap    = $signed({{(TAP_W-RAD_W){1'b0}}, r_ff});
      idx_tap  = $signed({2'b00, idx_ff});
      src_data = vert_ff ? temp_rd_data : frame_rd_data;

      case (state_ff)
         E_PRIME_RD: rd_pos = clamp_tap(tap_ff, n_len);
         E_WRITE:    rd_pos = clamp_tap(idx_tap + r_tap + TAP_W'(1), n_len);
         E_ADD_ACC:  rd_pos = clamp_tap(idx_tap - r_tap, n_len);
         default:    rd_pos = '0;
      endcase

      row  = vert_ff ? rd_pos : line_ff;
      col  = vert_ff ? line_ff : rd_pos;
      wrow = vert_ff ? idx_ff : line_ff;
      wcol = vert_ff ? line_ff : idx_ff;
      rd_addr = ADDR_W'(int'(row) * MAX_WIDTH + int'(col));
      wr_addr = ADDR_W'(int'(wrow) * MAX_WIDTH + int'(wcol));
      wr_data = {quo[0], quo[1], quo[2], quo[3]};

      mem_ctl.frame_we = (state_ff == E_WRITE) && vert_ff;
      mem_ctl.temp_we  = (state_ff == E_WRITE) && !vert_ff;
      mem_ctl.rd_en    = (state_ff == E_PRIME_RD) || (state_ff == E_WRITE) ||
                         (state_ff == E_ADD_ACC);
      mem_ctl.rd_temp  = vert_ff;
   end

   always_comb begin
      state_in  = state_ff;
      round_in  = round_ff;
      vert_in   = vert_ff;
      line_in   = line_ff;
      idx_in    = idx_ff;
      tap_in    = tap_ff;
      sums_in   = sums_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      r_in      = r_ff;
      done_in   = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               w_in     = wsat;
               h_in     = hsat;
               r_in     = rsat;
               round_in = '0;
               vert_in  = 1'b0;
               line_in  = '0;
               if (rsat == '0) begin
                  done_in = 1'b1;
               end else begin
                  state_in = E_LINE_INIT;
               end
            end
         end
         E_LINE_INIT: begin
            sums_in  = '0;
            tap_in   = -r_tap;
            state_in = E_PRIME_RD;
         end
         E_PRIME_RD: begin
            state_in = E_PRIME_ACC;
         end
         E_PRIME_ACC: begin
            for (int c = 0; c < NUM_CH; c++) begin
               sums_in[c] = sums_ff[c] + SUM_W'(pix_chan(src_data, c));
            end
            if (tap_ff == r_tap) begin
               idx_in   = '0;
               state_in = E_DIV_START;
            end else begin
               tap_in   = tap_ff + TAP_W'(1);
               state_in = E_PRIME_RD;
            end
         end
         E_DIV_START: begin
            div_start = 1'b1;
            state_in  = E_DIV_WAIT;
         end
         E_DIV_WAIT: begin
            if (div_done) begin
               state_in = E_WRITE;
            end
         end
         E_WRITE: begin
            state_in = E_ADD_ACC;
         end
         E_ADD_ACC: begin
            for (int c = 0; c < NUM_CH; c++) begin
               sums_in[c] = sums_ff[c] + SUM_W'(pix_chan(src_data, c));
            end
            state_in = E_SUB_ACC;
         end
         E_SUB_ACC: begin
            for (int c = 0; c < NUM_CH; c++) begin
               sums_in[c] = sums_ff[c] - SUM_W'(pix_chan(src_data, c));
            end
            if (idx_ff != n_len - 1'b1) begin
               idx_in   = idx_ff + 1'b1;
               state_in = E_DIV_START;
            end else if (line_ff != n_lines - 1'b1) begin
               line_in  = line_ff + 1'b1;
               state_in = E_LINE_INIT;
            end else begin
               line_in = '0;
               if (!vert_ff) begin
                  vert_in  = 1'b1;
                  state_in = E_LINE_INIT;
               end else if (round_ff != ROUND_W'(BLUR_ROUNDS - 1)) begin
                  vert_in  = 1'b0;
                  round_in = round_ff + 1'b1;
                  state_in = E_LINE_INIT;
               end else begin
                  done_in  = 1'b1;
                  state_in = E_IDLE;
               end
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
         sums_ff  <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         sums_ff  <= sums_in;
      end
      round_ff <= round_in;
      vert_ff  <= vert_in;
      line_ff  <= line_in;
      idx_ff   <= idx_in;
      tap_ff   <= tap_in;
      w_ff     <= w_in;
      h_ff     <= h_in;
      r_ff     <= r_in;
   end

   assign done = done_ff;

endmodule

### hdl/argb_triple_box_blur.sv
// Frame blur engine for premultiplied ARGB pixels held in an on-chip frame
// store of MAX_WIDTH x MAX_HEIGHT words. A write transaction stores one pixel
// and is acknowledged on the following cycle, so writes stream one per
// cycle while the response side takes each answer; a read transaction
// answers after the registered frame read and the T_READ state, and holds
// off the input while in that state. A start transaction runs three
// rounds of separable box blur (horizontal into a temporary store, vertical
// back into the frame, edges replicated) and answers when done. Each line of
// n pixels first primes the window sums over its 2r+1 taps, then for each
// pixel uses single-port reads for the entering and leaving taps and an
// 8-step shared divider. Radius zero finishes at once with the frame
// unchanged. Pixels outside the store read as zero and writes there are
// dropped but acknowledged; request type three is consumed silently.
`include "argb_triple_box_blur_defines.svh"

module argb_triple_box_blur import abtb_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [47:0]       req_tdata,  // pix_x, pix_y, in_alpha, in_red, in_green, in_blue
   input  logic [1:0]        req_tuser,  // req_type
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,  // out_alpha, out_red, out_green, out_blue
   output logic [1:0]        rsp_tuser,  // resp_kind
   input  logic              csr_we,
   input  logic [1:0]        csr_addr,
   input  logic [DIM_W-1:0]  csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   top_state_type     state_ff, state_in;
   logic [DIM_W-1:0]  width_ff, height_ff;
   logic [RAD_W-1:0]  radius_ff;
   logic              inside_ff, inside_in;
   logic              rsp_valid_ff, rsp_valid_in;
   req_type_type      rsp_kind_ff, rsp_kind_in;
   logic [PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;

   logic              accept, in_store, eng_start, eng_done, req_frame_we;
   req_type_type      req_kind;
   logic [7:0]        req_x, req_y;
   logic [ADDR_W-1:0] req_addr, eng_wr_addr, eng_rd_addr;
   logic [PIX_W-1:0]  eng_wr_data, frame_rd_data, temp_rd_data;
   mem_ctl_type       eng_ctl;

   logic              frame_we, frame_re;
   logic [ADDR_W-1:0] frame_wa, frame_ra;
   logic [PIX_W-1:0]  frame_wd;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(RST_WIDTH);
         height_ff <= DIM_W'(RST_HEIGHT);
         radius_ff <= RAD_W'(RST_RADIUS);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_RADIUS: radius_ff <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_x    = req_tdata[7:0];
   assign req_y    = req_tdata[15:8];
   assign req_kind = req_type_type'(req_tuser);
   assign in_store = (int'(req_x) < MAX_WIDTH) && (int'(req_y) < MAX_HEIGHT);
   assign req_addr = ADDR_W'(int'(req_y) * MAX_WIDTH + int'(req_x));

   assign req_tready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      inside_in    = inside_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_pix_in   = rsp_pix_ff;
      eng_start    = 1'b0;
      req_frame_we = 1'b0;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  REQ_WRITE: begin
                     req_frame_we = in_store;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = REQ_WRITE;
                     rsp_pix_in   = '0;
                  end
                  REQ_BLUR: begin
                     eng_start = 1'b1;
                     state_in  = T_BLUR;
                  end
                  REQ_READ: begin
                     inside_in = in_store;
                     state_in  = T_READ;
                  end
                  default: ;
               endcase
            end
         end
         T_READ: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = REQ_READ;
            rsp_pix_in   = inside_ff ? frame_rd_data : '0;
            state_in     = T_IDLE;
         end
         T_BLUR: begin
            if (eng_done) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = REQ_BLUR;
               rsp_pix_in   = '0;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      inside_ff   <= inside_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_pix_ff  <= rsp_pix_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {pix_chan(rsp_pix_ff, 3), pix_chan(rsp_pix_ff, 2),
                        pix_chan(rsp_pix_ff, 1), pix_chan(rsp_pix_ff, 0)};

   assign frame_we = (state_ff == T_BLUR) ? eng_ctl.frame_we : req_frame_we;
   assign frame_wa = (state_ff == T_BLUR) ? eng_wr_addr : req_addr;
   assign frame_wd = (state_ff == T_BLUR) ? eng_wr_data :
                     {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32], req_tdata[47:40]};
   assign frame_re = (state_ff == T_BLUR) ? (eng_ctl.rd_en && !eng_ctl.rd_temp) :
                     (accept && (req_kind == REQ_READ));
   assign frame_ra = (state_ff == T_BLUR) ? eng_rd_addr : req_addr;

   abtb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_frame (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (frame_wa),
      .wr_data (frame_wd),
      .rd_en   (frame_re),
      .rd_addr (frame_ra),
      .rd_data (frame_rd_data)
   );

   abtb_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_temp (
      .clock   (clock),
      .wr_en   (eng_ctl.temp_we),
      .wr_addr (eng_wr_addr),
      .wr_data (eng_wr_data),
      .rd_en   (eng_ctl.rd_en && eng_ctl.rd_temp),
      .rd_addr (eng_rd_addr),
      .rd_data (temp_rd_data)
   );

   abtb_engine #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .ADDR_W(ADDR_W)) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (eng_start),
      .img_width     (width_ff),
      .img_height    (height_ff),
      .blur_radius   (radius_ff),
      .frame_rd_data (frame_rd_data),
      .temp_rd_data  (temp_rd_data),
      .mem_ctl       (eng_ctl),
      .wr_addr       (eng_wr_addr),
      .rd_addr       (eng_rd_addr),
      .wr_data       (eng_wr_data),
      .done          (eng_done)
   );

   `ABTB_ASSERT_NOW(a_busy_blocks_req, clock, reset, state_ff != T_IDLE, !req_tready)
   `ABTB_ASSERT_NOW(a_done_in_blur, clock, reset, eng_done, state_ff == T_BLUR)
   `ABTB_ASSERT_NOW(a_engine_quiet, clock, reset, state_ff != T_BLUR, !eng_ctl.frame_we && !eng_ctl.temp_we && !eng_ctl.rd_en)
   `ABTB_ASSERT_NEXT(a_read_answers, clock, reset, accept && req_kind == REQ_READ, state_ff == T_READ)

endmodule
